FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define FVB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");

// Next-cycle implication, disabled while reset is high.
`define FVB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");

`endif

FILE: rtl/fvb_pkg.sv
// ---------------------------------------------------------------------------
// fvb_pkg
// Constants, types and float helpers of the feature value binner.
// ---------------------------------------------------------------------------
package fvb_pkg;

   localparam int MAX_FEATURES = 64;
   localparam int BIN_LIMIT    = 256;
   localparam int SLOTS        = ((BIN_LIMIT - 1) > 255) ? 255 : (BIN_LIMIT - 1);
   localparam int DEPTH        = MAX_FEATURES * SLOTS;
   localparam int ADDR_W       = $clog2(DEPTH);
   localparam int SEARCH_STEPS = $clog2(BIN_LIMIT);

   localparam int FEAT_W   = 6;
   localparam int ENTRY_W  = 8;
   localparam int COUNT_W  = 8;
   localparam int FCOUNT_W = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_COUNT = 2'd1;
   localparam logic [1:0] MODE_MAP   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_INF   = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_BAD   = 2'd3;

   localparam logic REG_INPUT_IS_DOUBLE = 1'b0;
   localparam logic REG_FEATURE_COUNT   = 1'b1;

   localparam logic [10:0] EXP64_ALL_ONES = 11'h7FF;
   localparam logic [10:0] EXP64_FMAX     = 11'd1150;
   localparam logic [10:0] EXP64_NORM_MIN = 11'd897;
   localparam logic [10:0] EXP64_REBIAS   = 11'd896;
   localparam logic [10:0] EXP64_SUB_BASE = 11'd926;
   localparam logic [10:0] EXP64_SUB_MIN  = 11'd871;
   localparam logic [5:0]  SUB_SHIFT_MAX  = 6'd55;

   typedef struct packed {
      logic [1:0]         mode;
      logic [FEAT_W-1:0]  feature_index;
      logic [ENTRY_W-1:0] entry_index;
      logic [31:0]        boundary_bits;
      logic [COUNT_W-1:0] boundary_total;
      logic [63:0]        sample_bits;
   } req_item_type;

   typedef struct packed {
      logic [COUNT_W-1:0] bin_index;
      logic               is_missing;
      logic [1:0]         status;
   } rsp_item_type;

   typedef struct packed {
      logic               active;
      logic [COUNT_W-1:0] first;
      logic [COUNT_W-1:0] len;
      logic [31:0]        value;
      logic [ADDR_W-1:0]  base;
      logic               missing;
      logic [1:0]         status;
   } search_token_type;

   typedef struct packed {
      logic        missing;
      logic [1:0]  status;
      logic [31:0] value;
   } conv_type;

   // IEEE less-than on float32 patterns; false when either side is a NaN.
   function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
      logic a_nan;
      logic b_nan;
      logic res;
      a_nan = (&a[30:23]) && (|a[22:0]);
      b_nan = (&b[30:23]) && (|b[22:0]);
      if (a_nan || b_nan) begin
         res = 1'b0;
      end else if ((a[30:0] == '0) && (b[30:0] == '0)) begin
         res = 1'b0;
      end else if (a[31] != b[31]) begin
         res = a[31];
      end else if (!a[31]) begin
         res = a[30:0] < b[30:0];
      end else begin
         res = a[30:0] > b[30:0];
      end
      return res;
   endfunction

   // Reads a sample as float32, or rounds a float64 to float32 nearest even.
   function automatic conv_type convert_sample(input logic [63:0] bits,
                                               input logic is_double);
      conv_type    r;
      logic [10:0] ex64;
      logic        sgn;
      logic [52:0] sig;
      logic [5:0]  sh;
      logic [116:0] ext;
      logic [30:0] mag;
      logic        rb;
      logic        sb;
      logic        inc;
      r.missing = 1'b0;
      r.status  = ST_OK;
      r.value   = bits[31:0];
      ex64 = bits[62:52];
      sgn  = bits[63];
      sig  = {(ex64 != '0), bits[51:0]};
      sh   = SUB_SHIFT_MAX;
      ext  = '0;
      mag  = '0;
      rb   = 1'b0;
      sb   = 1'b0;
      inc  = 1'b0;
      if (!is_double) begin
         if (&bits[30:23]) begin
            if (|bits[22:0]) begin
               r.missing = 1'b1;
            end else begin
               r.status = ST_INF;
            end
         end
      end else if (ex64 == EXP64_ALL_ONES) begin
         if (|bits[51:0]) begin
            r.missing = 1'b1;
         end else begin
            r.status = ST_INF;
            r.value  = {sgn, 8'hFF, 23'b0};
         end
      end else if ((ex64 > EXP64_FMAX) ||
                   ((ex64 == EXP64_FMAX) && (&bits[51:29]) && (|bits[28:0]))) begin
         r.status = ST_RANGE;
         r.value  = {sgn, 8'hFF, 23'b0};
      end else if (ex64 >= EXP64_NORM_MIN) begin
         mag = {8'(ex64 - EXP64_REBIAS), bits[51:29]};
         rb  = bits[28];
         sb  = |bits[27:0];
         inc = rb & (sb | mag[0]);
         r.value = {sgn, mag + 31'(inc)};
      end else begin
         if (ex64 >= EXP64_SUB_MIN) begin
            sh = 6'(EXP64_SUB_BASE - ex64);
         end
         ext = {sig, 64'b0} >> sh;
         mag = ext[94:64];
         rb  = ext[63];
         sb  = |ext[62:0];
         inc = rb & (sb | mag[0]);
         r.value = {sgn, mag + 31'(inc)};
      end
      return r;
   endfunction

endpackage

FILE: rtl/fvb_if.sv
// ---------------------------------------------------------------------------
// fvb channel interfaces
// Valid/ready channels for request and response transactions.
// ---------------------------------------------------------------------------
interface fvb_req_if;
   import fvb_pkg::*;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [FEAT_W-1:0]  feature_index;
   logic [ENTRY_W-1:0] entry_index;
   logic [31:0]        boundary_bits;
   logic [COUNT_W-1:0] boundary_total;
   logic [63:0]        sample_bits;

   modport source (output valid, mode, feature_index, entry_index, boundary_bits,
                   boundary_total, sample_bits, input ready);
   modport sink (input valid, mode, feature_index, entry_index, boundary_bits,
                 boundary_total, sample_bits, output ready);
endinterface

interface fvb_rsp_if;
   import fvb_pkg::*;
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] bin_index;
   logic               is_missing;
   logic [1:0]         status;

   modport source (output valid, bin_index, is_missing, status, input ready);
   modport sink (input valid, bin_index, is_missing, status, output ready);
endinterface

FILE: rtl/feature_value_binner_core.sv
// ---------------------------------------------------------------------------
// feature_value_binner_core
// Maps float samples to per-feature bin indices by lower-bound search.
// ---------------------------------------------------------------------------
//  Channel | Direction | Carries
//  req_if  | in        | boundary writes, count writes, samples
//  rsp_if  | out       | bin index, missing flag, status
//  APB     | in/out    | input_is_double, feature_count
//
// A sample is converted, then launched, then makes eight probes of the
// single-read boundary RAM, one per search cell, before its response is
// registered. The next request is taken only once the sample has left the
// search chain and the skid stage is empty. Boundary and count writes are
// registered at intake and written from there. Reset is synchronous; counts
// read as zero until written, and the boundary RAM is not cleared. A stalled
// response waits in an output register and a skid stage.
module feature_value_binner_core (
   input  logic                           clock,
   input  logic                           reset,
   fvb_req_if.sink                        req_if,
   fvb_rsp_if.source                      rsp_if,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fvb_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fvb_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fvb_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);
   import fvb_pkg::*;

   logic                input_is_double_ff;
   logic [FCOUNT_W-1:0] feature_count_ff;
   logic                csr_wr;

   req_item_type        s0_item_ff;
   logic                s0_valid_ff;
   logic [MAX_FEATURES-1:0] count_vld_ff;
   logic                s0_count_vld_ff;
   logic                count_we;
   logic [COUNT_W-1:0]  count_wr_data;
   logic [COUNT_W-1:0]  count_rd_data;

   search_token_type    launch_in;
   search_token_type    launch_ff;
   logic [ADDR_W-1:0]   launch_addr;
   conv_type            conv;
   logic                bad_feat;
   logic [ADDR_W-1:0]   s0_base;
   logic [COUNT_W-1:0]  s0_count;

   search_token_type    cell_tok [SEARCH_STEPS];
   logic [ADDR_W-1:0]   cell_addr [SEARCH_STEPS];
   logic [SEARCH_STEPS-1:0] cell_act;
   logic [ADDR_W-1:0]   rd_addr;
   logic [31:0]         rd_data;
   logic                ram_we;

   logic                busy;
   logic                accept;
   rsp_item_type        new_rsp;
   logic                new_valid;
   rsp_item_type        out_ff, out_in, skid_ff, skid_in;
   logic                out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic                pop;

   // Configuration port.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         input_is_double_ff <= 1'b0;
         feature_count_ff   <= FCOUNT_W'(1);
      end else if (csr_wr) begin
         if (paddr[2] == REG_INPUT_IS_DOUBLE) begin
            input_is_double_ff <= pwdata[0];
         end else begin
            feature_count_ff <= pwdata[FCOUNT_W-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_FEATURE_COUNT) ?
                   CSR_DATA_W'(feature_count_ff) : CSR_DATA_W'(input_is_double_ff);

   // Request intake.
   always_comb begin
      for (int i = 0; i < SEARCH_STEPS; i++) begin
         cell_act[i] = cell_tok[i].active;
      end
   end

   assign busy         = s0_valid_ff || launch_ff.active || (|cell_act);
   assign req_if.ready = !busy && !skid_valid_ff;
   assign accept       = req_if.valid && req_if.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
      if (accept) begin
         s0_item_ff <= '{mode: req_if.mode, feature_index: req_if.feature_index,
                         entry_index: req_if.entry_index,
                         boundary_bits: req_if.boundary_bits,
                         boundary_total: req_if.boundary_total,
                         sample_bits: req_if.sample_bits};
      end
   end

   // Boundary counts: a small RAM read as the request is accepted, with one
   // written flag per feature so that unwritten counts read as zero.
   assign count_we      = s0_valid_ff && (s0_item_ff.mode == MODE_COUNT);
   assign count_wr_data = (int'(s0_item_ff.boundary_total) > SLOTS) ? COUNT_W'(SLOTS) :
                                                                     s0_item_ff.boundary_total;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_vld_ff <= '0;
      end else if (count_we) begin
         count_vld_ff[s0_item_ff.feature_index] <= 1'b1;
      end
      s0_count_vld_ff <= count_vld_ff[req_if.feature_index];
   end

   fvb_ram #(
      .WIDTH(COUNT_W),
      .DEPTH(MAX_FEATURES)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (count_we),
      .wr_addr (s0_item_ff.feature_index),
      .wr_data (count_wr_data),
      .rd_addr (req_if.feature_index),
      .rd_data (count_rd_data)
   );

   // Conversion and launch of the search.
   assign s0_base  = ADDR_W'(s0_item_ff.feature_index) * ADDR_W'(SLOTS);
   assign s0_count = s0_count_vld_ff ? count_rd_data : '0;
   assign conv     = convert_sample(s0_item_ff.sample_bits, input_is_double_ff);
   assign bad_feat = {1'b0, s0_item_ff.feature_index} >= feature_count_ff;

   always_comb begin
      launch_in.active  = s0_valid_ff && (s0_item_ff.mode == MODE_MAP);
      launch_in.first   = '0;
      launch_in.len     = (bad_feat || conv.missing) ? '0 : s0_count;
      launch_in.value   = conv.value;
      launch_in.base    = s0_base;
      launch_in.missing = bad_feat ? 1'b0 : conv.missing;
      launch_in.status  = bad_feat ? ST_BAD : conv.status;
   end

   assign launch_addr = launch_in.active ?
                        (launch_in.base + ADDR_W'(launch_in.len >> 1)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_ff.active <= 1'b0;
      end else begin
         launch_ff <= launch_in;
      end
   end

   // Boundary RAM.
   assign ram_we = s0_valid_ff && (s0_item_ff.mode == MODE_WRITE) &&
                   (int'(s0_item_ff.entry_index) < SLOTS);

   always_comb begin
      rd_addr = launch_addr;
      for (int i = 0; i < SEARCH_STEPS; i++) begin
         rd_addr = rd_addr | cell_addr[i];
      end
   end

   fvb_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_boundary_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s0_base + ADDR_W'(s0_item_ff.entry_index)),
      .wr_data (s0_item_ff.boundary_bits),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Search chain.
   for (genvar g = 0; g < SEARCH_STEPS; g++) begin : g_cell
      if (g == 0) begin : g_first
         fvb_search_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .tok_in  (launch_ff),
            .rd_data (rd_data),
            .tok_out (cell_tok[g]),
            .rd_addr (cell_addr[g])
         );
      end else begin : g_next
         fvb_search_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .tok_in  (cell_tok[g-1]),
            .rd_data (rd_data),
            .tok_out (cell_tok[g]),
            .rd_addr (cell_addr[g])
         );
      end
   end

   // Response register and skid stage.
   assign new_valid = cell_tok[SEARCH_STEPS-1].active;
   assign new_rsp   = '{bin_index: cell_tok[SEARCH_STEPS-1].first,
                        is_missing: cell_tok[SEARCH_STEPS-1].missing,
                        status: cell_tok[SEARCH_STEPS-1].status};
   assign pop       = out_valid_ff && rsp_if.ready;

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_in       = new_rsp;
            skid_valid_in = new_valid;
         end else begin
            out_in       = new_rsp;
            out_valid_in = new_valid;
         end
      end else if (new_valid) begin
         skid_in       = new_rsp;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.bin_index  = out_ff.bin_index;
   assign rsp_if.is_missing = out_ff.is_missing;
   assign rsp_if.status     = out_ff.status;
endmodule

FILE: rtl/fvb_ram.sv
// ---------------------------------------------------------------------------
// fvb_ram
// Generic RAM with one write port and one registered read port.
// ---------------------------------------------------------------------------
module fvb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/fvb_search_cell.sv
// ---------------------------------------------------------------------------
// fvb_search_cell
// One halving step of the lower-bound search, handing its range onward.
// ---------------------------------------------------------------------------
module fvb_search_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  fvb_pkg::search_token_type tok_in,
   input  logic [31:0]               rd_data,
   output fvb_pkg::search_token_type tok_out,
   output logic [fvb_pkg::ADDR_W-1:0] rd_addr
);
   import fvb_pkg::*;

   search_token_type tok_in_c;
   search_token_type tok_ff;
   logic [COUNT_W-1:0] half;

   always_comb begin
      tok_in_c = tok_in;
      half     = tok_in.len >> 1;
      if (tok_in.active && (tok_in.len != '0)) begin
         if (flt_lt(rd_data, tok_in.value)) begin
            tok_in_c.first = tok_in.first + half + COUNT_W'(1);
            tok_in_c.len   = tok_in.len - half - COUNT_W'(1);
         end else begin
            tok_in_c.len = half;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff <= tok_in_c;
      end
   end

   assign rd_addr = tok_in_c.active ?
                    (tok_in_c.base + ADDR_W'(tok_in_c.first) + ADDR_W'(tok_in_c.len >> 1)) :
                    '0;
   assign tok_out = tok_ff;
endmodule

FILE: rtl/fvb_checker.sv
// ---------------------------------------------------------------------------
// fvb_checker
// Port-level assertions for the feature value binner core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fvb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [fvb_pkg::COUNT_W-1:0] rsp_bin_index,
   input logic                        rsp_is_missing,
   input logic [1:0]                  rsp_status
);
   import fvb_pkg::*;

   // A held response keeps its bin index and status.
   `FVB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_bin_index) && $stable(rsp_status))

   // One transaction at a time: intake closes after each acceptance.
   `FVB_ASSERT_NXT(a_req_busy, clock, reset, req_valid && req_ready, !req_ready)

   // A missing sample reports bin zero with ok status.
   `FVB_ASSERT_IMP(a_missing, clock, reset, rsp_valid && rsp_is_missing, rsp_bin_index == '0 && rsp_status == ST_OK)

   // A bad feature reports bin zero and no missing flag.
   `FVB_ASSERT_IMP(a_bad_feat, clock, reset, rsp_valid && rsp_status == ST_BAD, rsp_bin_index == '0 && !rsp_is_missing)
endmodule

bind feature_value_binner_core fvb_checker u_fvb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_bin_index  (rsp_if.bin_index),
   .rsp_is_missing (rsp_if.is_missing),
   .rsp_status     (rsp_if.status)
);

FILE: tb/feature_value_binner_core_tb.sv
// ---------------------------------------------------------------------------
// feature_value_binner_core_tb
// Self-checking bench for the feature value binner. A directed table and
// random boundary loads and samples go in through the request channel. An
// internal predictor mirrors the boundary and count stores and computes every
// expected bin, missing flag and status, in float32 and float64 modes.
// ---------------------------------------------------------------------------
module feature_value_binner_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import fvb_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      req_item_type item;
      bit           typed;
      rsp_item_type want;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   fvb_req_if req_bus();
   fvb_rsp_if rsp_bus();

   feature_value_binner_core dut (
      .clock(clock), .reset(reset), .req_if(req_bus), .rsp_if(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #2 clock = ~clock;

   logic [31:0] bound_mem [MAX_FEATURES][SLOTS];
   bit          bound_set [MAX_FEATURES][SLOTS];
   int          bound_cnt [MAX_FEATURES];
   bit          mode_double;
   int          feat_limit;
   rsp_item_type bin_q[$];
   int errors = 0;
   int cycles = 0;
   int items_sent = 0;
   bit quiet = 1'b0;
   int stall_left = 0;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_MAP;
      req_bus.feature_index = '0;
      req_bus.entry_index = '0;
      req_bus.boundary_bits = '0;
      req_bus.boundary_total = '0;
      req_bus.sample_bits = '0;
      rsp_bus.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("feature_value_binner_core_tb NOT OK");
         $finish;
      end
   end

   task automatic report(input string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic bit is_nan32(input logic [31:0] b);
      return (&b[30:23]) && (|b[22:0]);
   endfunction

   function automatic logic [31:0] order_key(input logic [31:0] b);
      if (b[30:0] == '0) return 32'h8000_0000;
      return b[31] ? ~b : (b | 32'h8000_0000);
   endfunction

   function automatic bit below(input logic [31:0] a, input logic [31:0] b);
      if (is_nan32(a) || is_nan32(b)) return 1'b0;
      return order_key(a) < order_key(b);
   endfunction

   function automatic logic [7:0] search_bin(input int f, input logic [31:0] v);
      int first;
      int len;
      int half;
      first = 0;
      len = bound_cnt[f];
      while (len > 0) begin
         half = len / 2;
         if (below(bound_mem[f][first + half], v)) begin
            first = first + half + 1;
            len = len - half - 1;
         end else begin
            len = half;
         end
      end
      return 8'(first);
   endfunction

   // Rounds an in-range float64 to float32, nearest even.
   function automatic logic [31:0] narrow(input logic [63:0] d);
      int ex;
      int sh;
      logic [52:0] sig;
      logic [116:0] ext;
      logic [52:0] m;
      logic [30:0] mag;
      ex = int'(d[62:52]);
      sig = {(ex != 0), d[51:0]};
      if (ex == 0) sh = 100;
      else sh = (926 - ex > 29) ? ((926 - ex > 100) ? 100 : 926 - ex) : 29;
      ext = {sig, 64'b0} >> sh;
      m = ext[116:64];
      m = m + 53'(ext[63] & ((|ext[62:0]) | ext[64]));
      mag = 31'(m);
      if (sh == 29) mag = 31'((ex - 897) << 23) + 31'(m);
      return {d[63], mag};
   endfunction

   function automatic bit predict(input req_item_type it, output rsp_item_type r);
      int f;
      logic [31:0] v;
      f = int'(it.feature_index);
      r = '0;
      if (it.mode == MODE_WRITE) begin
         if (it.entry_index < SLOTS) begin
            bound_mem[f][it.entry_index] = it.boundary_bits;
            bound_set[f][it.entry_index] = 1'b1;
         end
         return 1'b0;
      end
      if (it.mode == MODE_COUNT) begin
         bound_cnt[f] = (it.boundary_total > SLOTS) ? SLOTS : int'(it.boundary_total);
         return 1'b0;
      end
      if (it.mode != MODE_MAP) return 1'b0;
      if (f >= feat_limit) begin
         r.status = ST_BAD;
         return 1'b1;
      end
      if (!mode_double) begin
         v = it.sample_bits[31:0];
         if (is_nan32(v)) begin
            r.is_missing = 1'b1;
            return 1'b1;
         end
         if (&v[30:23]) r.status = ST_INF;
      end else begin
         if (it.sample_bits[62:52] == 11'h7FF) begin
            if (|it.sample_bits[51:0]) begin
               r.is_missing = 1'b1;
               return 1'b1;
            end
            r.status = ST_INF;
            v = {it.sample_bits[63], 31'h7F80_0000};
         end else if (it.sample_bits[62:0] > 63'h47EF_FFFF_E000_0000) begin
            r.status = ST_RANGE;
            v = {it.sample_bits[63], 31'h7F80_0000};
         end else begin
            v = narrow(it.sample_bits);
         end
      end
      r.bin_index = search_bin(f, v);
      return 1'b1;
   endfunction

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!quiet && !reset) begin
            if ($urandom_range(0, 99) < 8) stall_left <= $urandom_range(1, 3);
            else if ($urandom_range(0, 199) == 0) stall_left <= $urandom_range(10, 40);
         end
      end
   end

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (bin_q.size() == 0) begin
            report("response transaction with none expected");
         end else begin
            want = bin_q.pop_front();
            if (rsp_bus.bin_index !== want.bin_index)
               report($sformatf("bin_index %0d, expected %0d", rsp_bus.bin_index,
                                want.bin_index));
            if (rsp_bus.is_missing !== want.is_missing)
               report($sformatf("is_missing %0b, expected %0b", rsp_bus.is_missing,
                                want.is_missing));
            if (rsp_bus.status !== want.status)
               report($sformatf("status %0d, expected %0d", rsp_bus.status, want.status));
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 97) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic push_item(input req_item_type it, input bit typed, input rsp_item_type want);
      int gap;
      rsp_item_type r;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.mode = it.mode;
      req_bus.feature_index = it.feature_index;
      req_bus.entry_index = it.entry_index;
      req_bus.boundary_bits = it.boundary_bits;
      req_bus.boundary_total = it.boundary_total;
      req_bus.sample_bits = it.sample_bits;
      req_bus.valid = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      if (predict(it, r)) bin_q.insert(bin_q.size(), typed ? want : r);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send(input req_item_type it);
      push_item(it, 1'b0, '0);
   endtask

   task automatic drain();
      req_bus.valid = 1'b0;
      while (bin_q.size() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic set_mode(input bit dbl, input int fc);
      drain();
      csr_write(CSR_ADDR_W'(int'(REG_INPUT_IS_DOUBLE) * 4), 32'(dbl));
      csr_write(CSR_ADDR_W'(int'(REG_FEATURE_COUNT) * 4), 32'(fc));
      mode_double = dbl;
      feat_limit = fc;
   endtask

   function automatic req_item_type mk(input logic [1:0] md, input int f, input int e,
                                       input logic [31:0] bb, input int tot,
                                       input logic [63:0] s);
      req_item_type it;
      it.mode = md;
      it.feature_index = FEAT_W'(f);
      it.entry_index = ENTRY_W'(e);
      it.boundary_bits = bb;
      it.boundary_total = COUNT_W'(tot);
      it.sample_bits = s;
      return it;
   endfunction

   function automatic logic [31:0] rand_float();
      case ($urandom_range(0, 3))
         0: return {$urandom_range(0, 1) == 1, 8'($urandom_range(120, 134)),
                    23'($urandom_range(0, 7) << 20)};
         1: return {$urandom_range(0, 1) == 1, 31'($urandom_range(0, 40))};
         default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(0, 254)),
                          23'($urandom)};
      endcase
   endfunction

   // Loads n boundaries for a feature, sorted unless scrambled, then its count.
   task automatic load_feature(input int f, input int n, input bit scrambled);
      logic [31:0] vals [SLOTS];
      logic [31:0] t;
      int j;
      for (int i = 0; i < n; i++) begin
         vals[i] = rand_float();
         if (scrambled && $urandom_range(0, 4) == 0) vals[i] = {1'b0, 8'hFF, 23'($urandom | 1)};
      end
      if (!scrambled) begin
         for (int i = 1; i < n; i++) begin
            t = vals[i];
            j = i - 1;
            while (j >= 0 && order_key(vals[j]) > order_key(t)) begin
               vals[j + 1] = vals[j];
               j--;
            end
            vals[j + 1] = t;
         end
      end
      for (int i = 0; i < n; i++) send(mk(MODE_WRITE, f, i, vals[i], 0, '0));
      send(mk(MODE_COUNT, f, 0, '0, n, '0));
   endtask

   function automatic int written_prefix(input int f);
      int n;
      n = 0;
      while (n < SLOTS && bound_set[f][n]) n++;
      return n;
   endfunction

   function automatic logic [63:0] make_sample(input int f);
      logic [31:0] b;
      logic [63:0] d;
      int k;
      b = rand_float();
      if (bound_cnt[f] > 0 && $urandom_range(0, 2) != 0) begin
         b = bound_mem[f][$urandom_range(0, bound_cnt[f] - 1)];
         if (b[30:0] == '0 && $urandom_range(0, 1) == 1) b[31] = ~b[31];
      end
      k = $urandom_range(0, 19);
      if (!mode_double) begin
         case (k)
            0: b = {1'($urandom), 31'h7F80_0000};
            1: b = {1'($urandom), 8'hFF, 23'($urandom | 1)};
            2: b = {1'($urandom), 31'h7F7F_FFFF};
            3: b = $urandom;
            default: ;
         endcase
         return {32'($urandom), b};
      end
      if (b[30:23] == 0 || &b[30:23]) d = {b[31], 11'($urandom_range(860, 1160)), 52'($urandom)};
      else d = {b[31], 11'(int'(b[30:23]) + 896), b[22:0], 29'b0};
      case (k)
         0: d = {1'($urandom), 11'h7FF, 52'b0};
         1: d = {1'($urandom), 11'h7FF, 52'($urandom | 1)};
         2: d = {1'($urandom), 63'h47EF_FFFF_E000_0000};
         3: d = {1'($urandom), 63'h47EF_FFFF_E000_0001};
         4: d = {1'($urandom), 63'h47EF_FFFF_F000_0000};
         5: d = {$urandom, $urandom};
         6: d = {d[63:29], 29'h1000_0000};
         7: d = {d[63:29], 29'($urandom)};
         8: d = {1'($urandom), 11'($urandom_range(0, 880)), 20'($urandom), 32'($urandom)};
         default: ;
      endcase
      return d;
   endfunction

   task automatic random_phase(input int count);
      int stop;
      int f;
      int r;
      int p;
      stop = items_sent + count;
      while (items_sent < stop) begin
         r = $urandom_range(0, 19);
         f = (feat_limit < MAX_FEATURES && $urandom_range(0, 5) == 0) ?
             $urandom_range(0, MAX_FEATURES - 1) : $urandom_range(0, feat_limit - 1);
         if (r < 4) begin
            load_feature(f, ($urandom_range(0, 19) == 0) ? $urandom_range(0, SLOTS) :
                         $urandom_range(0, 16), $urandom_range(0, 4) == 0);
         end else if (r < 16) begin
            repeat ($urandom_range(1, 8))
               send(mk(MODE_MAP, f, $urandom, $urandom, $urandom, make_sample(f)));
         end else if (r == 16) begin
            send(mk(MODE_WRITE, f, $urandom_range(0, 255), rand_float(), $urandom, '0));
         end else if (r == 17) begin
            p = written_prefix(f);
            send(mk(MODE_COUNT, f, $urandom, $urandom, $urandom_range(0, p), '0));
         end else if (r == 18) begin
            send(mk(2'd3, f, $urandom, $urandom, $urandom, {$urandom, $urandom}));
         end else if ($urandom_range(0, 9) == 0) begin
            req_bus.valid = 1'b0;
            while (bin_q.size() != 0) @(negedge clock);
         end
      end
   endtask

   initial begin
      table_row_type rows [$];
      logic [31:0] v;
      mode_double = 1'b0;
      feat_limit = 1;
      for (int f = 0; f < MAX_FEATURES; f++) begin
         bound_cnt[f] = 0;
         for (int s = 0; s < SLOTS; s++) begin
            bound_mem[f][s] = '0;
            bound_set[f][s] = 1'b0;
         end
      end
      rows = '{
         '{mk(MODE_MAP, 0, 0, '0, 0, 64'h0), 1'b1, '{8'd0, 1'b0, ST_OK}},
         '{mk(MODE_MAP, 1, 0, '0, 0, 64'h0), 1'b1, '{8'd0, 1'b0, ST_BAD}},
         '{mk(MODE_MAP, 63, 0, '0, 0, 64'h0), 1'b1, '{8'd0, 1'b0, ST_BAD}},
         '{mk(MODE_MAP, 0, 0, '0, 0, 64'h7FC0_0000), 1'b1, '{8'd0, 1'b1, ST_OK}},
         '{mk(MODE_MAP, 0, 0, '0, 0, 64'hFFFF_FFFF), 1'b1, '{8'd0, 1'b1, ST_OK}},
         '{mk(MODE_MAP, 0, 0, '0, 0, 64'h7F80_0000), 1'b1, '{8'd0, 1'b0, ST_INF}},
         '{mk(2'd3, 63, 255, '1, 255, '1), 1'b0, '0},
         '{mk(MODE_WRITE, 0, 0, 32'hBF80_0000, 0, '0), 1'b0, '0},
         '{mk(MODE_WRITE, 0, 1, 32'h0000_0000, 0, '0), 1'b0, '0},
         '{mk(MODE_WRITE, 0, 2, 32'h3F80_0000, 0, '0), 1'b0, '0},
         '{mk(MODE_WRITE, 0, 255, 32'hFFFF_FFFF, 0, '0), 1'b0, '0},
         '{mk(MODE_COUNT, 0, 0, '0, 3, '0), 1'b0, '0},
         '{mk(MODE_MAP, 0, 0, '0, 0, 64'h8000_0000), 1'b0, '0},
         '{mk(MODE_MAP, 0, 0, '0, 0, 64'h3F80_0000), 1'b0, '0},
         '{mk(MODE_MAP, 0, 0, '0, 0, 64'h4000_0000), 1'b0, '0},
         '{mk(MODE_MAP, 0, 0, '0, 0, 64'hFF80_0000), 1'b0, '0},
         '{mk(MODE_MAP, 0, 0, '0, 0, 64'h7F7F_FFFF), 1'b0, '0},
         '{mk(MODE_MAP, 0, 0, '0, 0, 64'h0000_0001), 1'b0, '0},
         '{mk(MODE_MAP, 0, 0, '0, 0, 64'hFFFF_FFFF_BF80_0000), 1'b0, '0}
      };
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (rows[i]) push_item(rows[i].item, rows[i].typed, rows[i].want);
      v = 32'hC700_0000;
      for (int i = 0; i < SLOTS; i++) begin
         send(mk(MODE_WRITE, 0, i, v, 0, '0));
         v = v[31] ? ((v[30:0] > 31'h0080_0000) ? v - 32'h0008_0000 : 32'h0000_0000)
                   : v + 32'h0008_0000;
      end
      send(mk(MODE_COUNT, 0, 0, '0, SLOTS, '0));
      repeat (20) send(mk(MODE_MAP, 0, 0, '0, 0, make_sample(0)));
      set_mode(1'b0, 64);
      random_phase(300);
      set_mode(1'b1, 64);
      random_phase(300);
      quiet = 1'b1;
      set_mode(1'b1, 1);
      random_phase(100);
      quiet = 1'b0;
      set_mode(1'b0, 37);
      random_phase(250);
      set_mode(1'b1, 37);
      random_phase(250);
      set_mode(1'b0, 64);
      random_phase(300);
      drain();
      if (errors == 0) begin
         $display("feature_value_binner_core_tb OK");
      end else begin
         $display("feature_value_binner_core_tb NOT OK");
      end
      $finish;
   end
endmodule

FILE: feature_value_binner_core.f
+incdir+rtl
rtl/fvb_pkg.sv
rtl/fvb_if.sv
rtl/fvb_ram.sv
rtl/fvb_search_cell.sv
rtl/feature_value_binner_core.sv
rtl/fvb_checker.sv
tb/feature_value_binner_core_tb.sv
